FILE: design/mvt_pkg.sv
// Shared definitions for the 4x4 matrix-vector transform block.
// Word formats, pipeline widths, request codes and lane control struct.
// No dependencies.
`default_nettype none

package mvt_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ELEM_W     = 32;
    localparam int DIM        = 4;
    localparam int IDX_W      = $clog2(DIM);
    localparam int PROD_W     = 2 * WORD_WIDTH;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;

    typedef logic signed [WORD_WIDTH-1:0] t_word;
    typedef logic signed [ELEM_W-1:0]     t_elem;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [PAIR_W-1:0]     t_pair;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic [IDX_W-1:0]             t_idx;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    localparam t_sum  HALF_LSB = t_sum'(1) <<< (FRAC_BITS - 1);
    localparam t_word WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic en_prod;
        logic en_pair;
        logic en_sum;
    } t_lane_ctl;

    // Sign-extend or truncate a port element to the internal word.
    function automatic t_word to_word(input t_elem x);
        logic [WORD_WIDTH+ELEM_W-1:0] ext;
        ext = {{WORD_WIDTH{x[ELEM_W-1]}}, x};
        return ext[WORD_WIDTH-1:0];
    endfunction

    // Place the internal word on a port element, upper bits zero.
    function automatic t_elem to_elem(input t_word w);
        logic [WORD_WIDTH+ELEM_W-1:0] ext;
        ext = {{ELEM_W{1'b0}}, w};
        return ext[ELEM_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/mvt_lane.sv
// One row lane: four products, pair sums, total with rounding offset,
// then rounding shift and saturation. Depends on mvt_pkg.
`default_nettype none

module mvt_lane (
    input  wire logic               i_clk,
    input  wire mvt_pkg::t_lane_ctl i_ctl,
    input  wire mvt_pkg::t_word     i_row [mvt_pkg::DIM],
    input  wire mvt_pkg::t_word     i_vec [mvt_pkg::DIM],
    output mvt_pkg::t_word          o_word,
    output logic                    o_sat
);
    import mvt_pkg::*;

    t_prod r_prod [DIM];
    t_pair r_pair [2];
    t_sum  r_sum;
    t_sum  shifted;
    logic  fits;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_prod) begin
            for (int c = 0; c < DIM; c++) begin
                r_prod[c] <= t_prod'(i_row[c]) * t_prod'(i_vec[c]);
            end
        end
        if (i_ctl.en_pair) begin
            r_pair[0] <= t_pair'(r_prod[0]) + t_pair'(r_prod[1]);
            r_pair[1] <= t_pair'(r_prod[2]) + t_pair'(r_prod[3]);
        end
        if (i_ctl.en_sum) begin
            r_sum <= t_sum'(r_pair[0]) + t_sum'(r_pair[1]) + HALF_LSB;
        end
    end

    // floor after the half-LSB offset gives round to nearest, ties upward
    always_comb begin
        shifted = r_sum >>> FRAC_BITS;
        fits    = (shifted[SUM_W-1:WORD_WIDTH-1] == '0) ||
                  (shifted[SUM_W-1:WORD_WIDTH-1] == '1);
        o_sat   = !fits;
        if (fits) begin
            o_word = shifted[WORD_WIDTH-1:0];
        end else begin
            o_word = r_sum[SUM_W-1] ? WORD_MIN : WORD_MAX;
        end
    end

endmodule

`default_nettype wire

FILE: design/mvt_merge.sv
// Merging stage: collects the four lane words, ORs the saturation flags
// and holds the result in the output register. Depends on mvt_pkg.
`default_nettype none

module mvt_merge (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire logic           i_stall,
    input  wire mvt_pkg::t_word i_word [mvt_pkg::DIM],
    input  wire logic           i_sat  [mvt_pkg::DIM],
    output logic                o_ready,
    output logic                o_valid,
    output mvt_pkg::t_word      o_word [mvt_pkg::DIM],
    output logic                o_saturated
);
    import mvt_pkg::*;

    logic  r_valid;
    t_word r_word [DIM];
    logic  r_sat;
    logic  any_sat;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        any_sat = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            any_sat = any_sat | i_sat[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_word <= i_word;
            r_sat  <= any_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_word      = r_word;
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

FILE: design/matrix_vector_transform_4x4.sv
// Top level of the 4x4 matrix-vector transform in signed Q16.16.
// Holds the matrix, runs four row lanes and the merging output stage.
// Depends on mvt_pkg, mvt_lane and mvt_merge.
`default_nettype none

//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_req_type, i_column_index, i_elem_0..3
//  result    out        o_valid / i_stall    o_out_0..3, o_saturated
//
//  A request moves when valid is high and stall is low at a rising edge.
//  A load request writes its column at that edge and gives no result; a
//  transform request issued in the next cycle already sees the new column.
//  A transform shows on o_valid after these registers in order: products are
//  registered at the accepting edge, then pair sums, total with rounding
//  offset, then round/saturate into the output register. One request per
//  cycle is sustained while i_stall stays low; each of the four lanes holds
//  four 32x32 multipliers.
//  Reset (synchronous, active low) clears the matrix and all valid bits.
//  A stalled result holds; earlier stages keep filling bubbles and stall
//  the request side only when every stage is occupied.

module matrix_vector_transform_4x4 (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic         i_req_type,
    input  wire logic [1:0]   i_column_index,
    input  wire logic [31:0]  i_elem_0,
    input  wire logic [31:0]  i_elem_1,
    input  wire logic [31:0]  i_elem_2,
    input  wire logic [31:0]  i_elem_3,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [31:0]       o_out_0,
    output logic [31:0]       o_out_1,
    output logic [31:0]       o_out_2,
    output logic [31:0]       o_out_3,
    output logic              o_saturated
);
    import mvt_pkg::*;

    // matrix held as [column][row], matching the column-major load
    t_word r_matrix [DIM][DIM];

    // pipeline occupancy: products, pair sums, totals
    logic r_v_prod;
    logic r_v_pair;
    logic r_v_sum;

    logic      rdy_prod, rdy_pair, rdy_sum, rdy_out;
    logic      accept, acc_load, acc_xform;
    t_word     vec [DIM];
    t_word     lane_row  [DIM][DIM];
    t_word     lane_word [DIM];
    logic      lane_sat  [DIM];
    t_word     res_word  [DIM];
    t_lane_ctl lane_ctl;

    // A stage may take new contents when empty or when its occupant moves on.
    assign rdy_sum  = !r_v_sum  || rdy_out;
    assign rdy_pair = !r_v_pair || rdy_sum;
    assign rdy_prod = !r_v_prod || rdy_pair;

    assign o_stall   = !rdy_prod;
    assign accept    = i_valid && rdy_prod;
    assign acc_load  = accept && (i_req_type == REQ_LOAD);
    assign acc_xform = accept && (i_req_type == REQ_XFORM);

    assign vec[0] = to_word(i_elem_0);
    assign vec[1] = to_word(i_elem_1);
    assign vec[2] = to_word(i_elem_2);
    assign vec[3] = to_word(i_elem_3);

    assign lane_ctl.en_prod = acc_xform;
    assign lane_ctl.en_pair = rdy_pair && r_v_prod;
    assign lane_ctl.en_sum  = rdy_sum  && r_v_pair;

    // Write the addressed column on a load request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < DIM; c++) begin
                for (int r = 0; r < DIM; r++) begin
                    r_matrix[c][r] <= '0;
                end
            end
        end else if (acc_load) begin
            for (int r = 0; r < DIM; r++) begin
                r_matrix[i_column_index][r] <= vec[r];
            end
        end
    end

    // Advance occupancy bits; a stage that cannot move holds its bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_pair <= 1'b0;
            r_v_sum  <= 1'b0;
        end else begin
            if (rdy_prod) begin
                r_v_prod <= acc_xform;
            end
            if (rdy_pair) begin
                r_v_pair <= r_v_prod;
            end
            if (rdy_sum) begin
                r_v_sum <= r_v_pair;
            end
        end
    end

    // Lane r sees row r of the matrix: entry (r, c) from each column c.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                lane_row[r][c] = r_matrix[c][r];
            end
        end
    end

    for (genvar g = 0; g < DIM; g++) begin : g_lane
        mvt_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_row  (lane_row[g]),
            .i_vec  (vec),
            .o_word (lane_word[g]),
            .o_sat  (lane_sat[g])
        );
    end

    mvt_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_v_sum),
        .i_stall     (i_stall),
        .i_word      (lane_word),
        .i_sat       (lane_sat),
        .o_ready     (rdy_out),
        .o_valid     (o_valid),
        .o_word      (res_word),
        .o_saturated (o_saturated)
    );

    assign o_out_0 = to_elem(res_word[0]);
    assign o_out_1 = to_elem(res_word[1]);
    assign o_out_2 = to_elem(res_word[2]);
    assign o_out_3 = to_elem(res_word[3]);

endmodule

`default_nettype wire
